// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/phdc_pkg.sv =====
package phdc_pkg;

   // Result field widths
   localparam int COUNT_W = 8;
   localparam int PSUM_W  = 18;
   localparam int MEAN_W  = 8;

   // Result transfer packing: is_perfect, is_harmonic, count, proper sum, mean
   localparam int RSP_FIELDS_W = 2 + COUNT_W + PSUM_W + MEAN_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_TRIAL,
      ST_PRODUCT,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_FINISH
   } seq_state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/phdc_divider.sv =====
module phdc_divider #(
   parameter int DVD_W = 26,
   parameter int DVS_W = 19
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [DVD_W-1:0]       dividend,
   input  logic [DVS_W-1:0]       divisor,
   output logic [DVD_W-1:0]       quotient,
   output logic [DVS_W-1:0]       remainder,
   output phdc_pkg::div_status_type status
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;

   // One restoring step: shift in next dividend bit, subtract when it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   `ASSERT_ALWAYS(a_no_restart, clock, reset, !(start && busy_ff), "divider restarted while busy")
   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && !done_ff, "divider did not start")

endmodule

// ===== hw/rtl/perfect_harmonic_divisor_check_top.sv =====
// Every trial division runs on the shared one-bit-per-cycle divider, DVD_W = 3*NUM_BITS/2 + 2
// (26 at the default width).
// Throughput: one number at a time; req_tready is high only while the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer, divider control and result valid.
module perfect_harmonic_divisor_check_top #(
   parameter int NUM_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // req_tdata fields from bit 0: number
   input  logic [((NUM_BITS + 7) / 8) * 8-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata fields from bit 0: is_perfect, is_harmonic, divisor_count, proper_sum,
   // harmonic_mean
   output logic [phdc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   `include "assert_macros.svh"

   localparam int D_W   = NUM_BITS / 2 + 1;
   localparam int SQ_W  = 2 * D_W;
   localparam int CNT_W = D_W + 1;
   localparam int SUM_W = NUM_BITS + 3;
   localparam int DVD_W = CNT_W + NUM_BITS;

   phdc_pkg::seq_state_type state_ff, state_in;

   logic [NUM_BITS-1:0]         n_ff, n_in;
   logic [D_W-1:0]              d_ff, d_in;
   logic [SQ_W-1:0]             sq_ff, sq_in;
   logic [SUM_W-1:0]            sigma_ff, sigma_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [DVD_W-1:0]            num_ff, num_in;
   logic                        harm_ff, harm_in;
   logic [phdc_pkg::MEAN_W-1:0] mean_ff, mean_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [phdc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                        div_start;
   logic [DVD_W-1:0]            div_dividend;
   logic [SUM_W-1:0]            div_divisor;
   logic [DVD_W-1:0]            div_quotient;
   logic [SUM_W-1:0]            div_remainder;
   phdc_pkg::div_status_type    div_status;

   logic                        pair;
   logic [DVD_W-1:0]            product;
   logic [SUM_W-1:0]            proper;
   logic                        perfect;
   logic                        load_rsp;
   logic [CNT_W+phdc_pkg::COUNT_W-1:0] cnt_ext;
   logic [SUM_W+phdc_pkg::PSUM_W-1:0]  proper_ext;
   logic [DVD_W+phdc_pkg::MEAN_W-1:0]  mean_ext;

   phdc_divider #(
      .DVD_W (DVD_W),
      .DVS_W (SUM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_status)
   );

   // Cofactor differs from the trial divisor: both count
   assign pair    = div_quotient != DVD_W'(d_ff);
   assign product = DVD_W'(cnt_ff) * DVD_W'(n_ff);

   // Proper divisor sum and perfect flag
   assign proper  = (n_ff != '0) ? (sigma_ff - SUM_W'(n_ff)) : '0;
   assign perfect = proper == SUM_W'(n_ff);

   // Fit results to their field widths
   assign cnt_ext    = {{phdc_pkg::COUNT_W{1'b0}}, cnt_ff};
   assign proper_ext = {{phdc_pkg::PSUM_W{1'b0}}, proper};
   assign mean_ext   = {{phdc_pkg::MEAN_W{1'b0}}, div_quotient};

   assign load_rsp = (state_ff == phdc_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      sigma_in     = sigma_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      harm_in      = harm_ff;
      mean_in      = mean_ff;
      div_start    = 1'b0;
      div_dividend = DVD_W'(n_ff);
      div_divisor  = SUM_W'(d_ff);
      req_tready   = 1'b0;
      unique case (state_ff)
         phdc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               n_in     = req_tdata[NUM_BITS-1:0];
               d_in     = D_W'(1);
               sq_in    = SQ_W'(1);
               sigma_in = '0;
               cnt_in   = '0;
               state_in = phdc_pkg::ST_TEST;
            end
         end
         phdc_pkg::ST_TEST: begin
            if (sq_ff <= SQ_W'(n_ff)) begin
               div_start = 1'b1;
               state_in  = phdc_pkg::ST_TRIAL;
            end else begin
               state_in = phdc_pkg::ST_PRODUCT;
            end
         end
         phdc_pkg::ST_TRIAL: begin
            if (div_status.done) begin
               if (div_remainder == '0) begin
                  sigma_in = sigma_ff + SUM_W'(d_ff)
                             + (pair ? div_quotient[SUM_W-1:0] : '0);
                  cnt_in   = cnt_ff + (pair ? CNT_W'(2) : CNT_W'(1));
               end
               // Advance trial divisor, keep square in step
               d_in     = d_ff + D_W'(1);
               sq_in    = sq_ff + SQ_W'({d_ff, 1'b1});
               state_in = phdc_pkg::ST_TEST;
            end
         end
         phdc_pkg::ST_PRODUCT: begin
            num_in = product;
            if (sigma_ff == '0) begin
               harm_in  = 1'b0;
               mean_in  = '0;
               state_in = phdc_pkg::ST_FINISH;
            end else begin
               state_in = phdc_pkg::ST_MEAN_START;
            end
         end
         phdc_pkg::ST_MEAN_START: begin
            div_start    = 1'b1;
            div_dividend = num_ff;
            div_divisor  = sigma_ff;
            state_in     = phdc_pkg::ST_MEAN_WAIT;
         end
         phdc_pkg::ST_MEAN_WAIT: begin
            if (div_status.done) begin
               harm_in  = div_remainder == '0;
               mean_in  = (div_remainder == '0) ? mean_ext[phdc_pkg::MEAN_W-1:0] : '0;
               state_in = phdc_pkg::ST_FINISH;
            end
         end
         phdc_pkg::ST_FINISH: begin
            if (load_rsp) begin
               state_in = phdc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = phdc_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register: load on finish, drop after the transfer
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = phdc_pkg::RSP_DATA_W'({mean_ff,
                                              proper_ext[phdc_pkg::PSUM_W-1:0],
                                              cnt_ext[phdc_pkg::COUNT_W-1:0],
                                              harm_ff,
                                              perfect});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= phdc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      sq_ff       <= sq_in;
      sigma_ff    <= sigma_in;
      cnt_ff      <= cnt_in;
      num_ff      <= num_in;
      harm_ff     <= harm_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_ALWAYS(a_square_track, clock, reset, (state_ff == phdc_pkg::ST_IDLE) || (sq_ff == SQ_W'(d_ff) * SQ_W'(d_ff)), "square out of step with trial divisor")
   `ASSERT_NEXT(a_result_load, clock, reset, (state_ff == phdc_pkg::ST_FINISH) && rsp_tready, rsp_tvalid && (state_ff == phdc_pkg::ST_IDLE), "result not loaded on finish")

endmodule
